// File: rtl/fihoe_pkg.sv
`default_nettype none
package fihoe_pkg;

    localparam int MS_W      = 16;
    localparam int STEP_W    = 17;
    localparam int LEVEL_W   = 17;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(65536);
    localparam logic [STEP_W-1:0]  STEP_MAX   = STEP_W'(131071);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = CFG_IDX_W'(2);

    typedef enum logic [PHASE_W-1:0] {
        PH_START  = 3'd0,
        PH_START2 = 3'd1,
        PH_IN     = 3'd2,
        PH_HOLD   = 3'd3,
        PH_OUT    = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_DIV,
        SQ_PUSH
    } t_seq;

    typedef struct packed {
        logic [MS_W-1:0] elapsed_ms;
        logic            stop_hold;
    } t_in_word;

    typedef struct packed {
        logic [LEVEL_W-1:0] fade_level;
        logic               fade_written;
        logic [PHASE_W-1:0] phase_now;
    } t_out_word;

    typedef struct packed {
        logic            start;
        logic [MS_W-1:0] num;
        logic [MS_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [MS_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

// File: rtl/fihoe_in_if.sv
`default_nettype none
interface fihoe_in_if;
    import fihoe_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/fihoe_out_if.sv
`default_nettype none
interface fihoe_out_if;
    import fihoe_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/fihoe_div.sv
`default_nettype none
module fihoe_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fihoe_pkg::t_div_req i_req,
    output fihoe_pkg::t_div_rsp      o_rsp
);
    import fihoe_pkg::*;

    // Restoring division of (num << 16) by den, one quotient bit a cycle.
    // The caller keeps num below den, so the remainder fits in MS_W bits.
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MS_W-1:0]      r_rem;
    logic [MS_W-1:0]      r_den;
    logic [MS_W-1:0]      r_quo;

    logic [MS_W:0] shifted;
    logic [MS_W:0] diff;
    logic          ge;

    always_comb begin
        shifted = {r_rem, 1'b0};
        ge      = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[MS_W-1:0] : shifted[MS_W-1:0];
            r_quo <= {r_quo[MS_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

// File: rtl/fade_in_hold_out_envelope.sv
// Channel   | Dir | Word                                  | Handshake
// ----------+-----+---------------------------------------+--------------
// i_in      | in  | elapsed_ms[15:0], stop_hold           | valid / ready
// o_out     | out | fade_level[16:0], fade_written,       | valid / ready
//           |     | phase_now[2:0]                        |
// i_cfg_*   | in  | i_cfg_idx selects, i_cfg_data[15:0]   | i_cfg_we
//
// A ramp tick goes through a shared bit-serial divider, which gives one quotient bit
// per cycle; other ticks skip the divider and go straight to the output register.
// i_in.ready is high only while the sequencer is idle; one word is in work.
// A finished word waits in the output register; a stalled sink holds it and
// the sequencer waits for the slot before going idle again.
// Synchronous active-low reset clears phase, accumulator, stop-hold flag, sequencer, output valid and config registers.
`default_nettype none
module fade_in_hold_out_envelope (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    fihoe_in_if.sink                                i_in,
    fihoe_out_if.source                             o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [fihoe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fihoe_pkg::MS_W-1:0]         i_cfg_data
);
    import fihoe_pkg::*;

    // configuration registers
    logic [MS_W-1:0] r_fade_in_ms;
    logic [MS_W-1:0] r_fade_out_ms;
    logic [MS_W-1:0] r_hold_ms;

    // envelope state
    t_seq              r_seq, n_seq;
    t_phase            r_phase, n_phase;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_hc, n_hc;

    // word being built, and the output slot
    t_out_word r_res, n_res;
    t_out_word r_out_word;
    logic      r_out_valid;
    logic      out_load;
    logic      in_ready;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic              hc_now;
    logic [MS_W-1:0]   hold_len;
    logic [STEP_W:0]   sum;
    logic [STEP_W-1:0] step_sat;
    logic [MS_W-1:0]   out_num;

    fihoe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in_ms  <= '0;
            r_fade_out_ms <= '0;
            r_hold_ms     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FADE_IN:  r_fade_in_ms  <= i_cfg_data;
                CFG_FADE_OUT: r_fade_out_ms <= i_cfg_data;
                CFG_HOLD:     r_hold_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= SQ_IDLE;
            r_phase <= PH_START;
            r_step  <= '0;
            r_hc    <= 1'b0;
        end else begin
            r_seq   <= n_seq;
            r_phase <= n_phase;
            r_step  <= n_step;
            r_hc    <= n_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // output slot: load a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= r_res;
        end
    end

    // shared helpers for the accepted tick
    always_comb begin
        hc_now   = r_hc | i_in.data.stop_hold;
        hold_len = hc_now ? '0 : r_hold_ms;
        sum      = {1'b0, r_step} + (STEP_W + 1)'(i_in.data.elapsed_ms);
        step_sat = sum[STEP_W] ? STEP_MAX : sum[STEP_W-1:0];
        // only used while r_step < fade_out_ms, so the low bits suffice
        out_num  = r_fade_out_ms - r_step[MS_W-1:0];
    end

    always_comb begin
        n_seq    = r_seq;
        n_phase  = r_phase;
        n_step   = r_step;
        n_hc     = r_hc;
        n_res    = r_res;
        div_req  = '0;
        out_load = 1'b0;
        in_ready = 1'b0;

        case (r_seq)
            SQ_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_hc  = hc_now;
                    n_res = '0;
                    n_seq = SQ_PUSH;
                    case (r_phase)
                        PH_START, PH_START2: begin
                            n_res.fade_written = (r_fade_in_ms != '0);
                            n_step  = '0;
                            n_phase = (r_phase == PH_START) ? PH_START2 : PH_IN;
                        end
                        PH_IN: begin
                            if (r_step < STEP_W'(r_fade_in_ms)) begin
                                // level = step * 65536 / fade_in
                                n_res.fade_written = 1'b1;
                                div_req.start      = 1'b1;
                                div_req.num        = r_step[MS_W-1:0];
                                div_req.den        = r_fade_in_ms;
                                n_seq              = SQ_DIV;
                                n_step             = step_sat;
                            end else begin
                                n_res.fade_written = 1'b1;
                                n_res.fade_level   = FULL_LEVEL;
                                n_step             = '0;
                                n_phase            = PH_HOLD;
                            end
                        end
                        PH_HOLD: begin
                            if (r_step < STEP_W'(hold_len)) begin
                                n_step = step_sat;
                            end else begin
                                n_step  = '0;
                                n_phase = PH_OUT;
                            end
                        end
                        PH_OUT: begin
                            n_res.fade_written = 1'b1;
                            if (r_fade_out_ms == '0) begin
                                // no ramp: jump to full, then done
                                n_res.fade_level = FULL_LEVEL;
                                n_step           = '0;
                                n_phase          = PH_DONE;
                            end else if (r_step < STEP_W'(r_fade_out_ms)) begin
                                n_step = step_sat;
                                if (r_step == '0) begin
                                    n_res.fade_level = FULL_LEVEL;
                                end else begin
                                    div_req.start = 1'b1;
                                    div_req.num   = out_num;
                                    div_req.den   = r_fade_out_ms;
                                    n_seq         = SQ_DIV;
                                end
                            end else begin
                                n_step  = '0;
                                n_phase = PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                    n_res.phase_now = n_phase;
                end
            end
            SQ_DIV: begin
                if (div_rsp.done) begin
                    n_res.fade_level = {1'b0, div_rsp.quo};
                    n_seq            = SQ_PUSH;
                end
            end
            SQ_PUSH: begin
                // hold the word until the output slot is free
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_seq    = SQ_IDLE;
                end
            end
            default: n_seq = SQ_IDLE;
        endcase
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import fihoe_pkg::*;

    localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving on either channel
    localparam int RANDOM_TICKS  = 800;
    localparam int SEGMENT_TICKS = 12;
    localparam int TAIL_CYCLES   = 40;    // longer than a division tick takes

    // Kinds of row in the opening table: a register write or a tick word.
    typedef enum logic {
        ROW_REG,
        ROW_TICK
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [MS_W-1:0]       value;   // register value, or elapsed_ms of a tick
        logic                  stop;
        logic                  typed;   // result below is known by eye
        t_out_word             result;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [MS_W-1:0]      cfg_data;

    fihoe_in_if  tick_ch ();
    fihoe_out_if level_ch ();

    fade_in_hold_out_envelope DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_ch),
        .o_out      (level_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Envelope mirror: phase, accumulated milliseconds and the stop-hold latch,
    // plus our own copy of the three duration registers.
    t_phase            env_phase;
    logic [STEP_W-1:0] env_step;
    logic              hold_dropped;
    logic [MS_W-1:0]   ramp_in_ms;
    logic [MS_W-1:0]   ramp_out_ms;
    logic [MS_W-1:0]   hold_time_ms;

    t_out_word due_words[$];   // levels still owed by the block, oldest first
    int        mismatches  = 0;
    int        burst_left  = 0;
    int        ticks_sent  = 0;
    int        stall_clock = 0;
    int        quiet_cycles = 0;

    // Opening table: start phases with and without a ramp, then the head of
    // the fade-in ramp from a standing start.
    t_row opening_rows [12] = '{
        '{ROW_REG,  CFG_FADE_OUT, 16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_HOLD,     16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_REG,  CFG_FADE_IN,  16'h0000, 1'b0, 1'b0, '0},
        // no ramp set: first start writes nothing and ignores elapsed time
        '{ROW_TICK, CFG_FADE_IN,  16'hFFFF, 1'b0, 1'b1, t_out_word'{17'd0, 1'b0, PH_START2}},
        '{ROW_REG,  CFG_FADE_IN,  16'hFFFF, 1'b0, 1'b0, '0},
        // ramp set: second start writes black
        '{ROW_TICK, CFG_FADE_IN,  16'hFFFF, 1'b0, 1'b1, t_out_word'{17'd0, 1'b1, PH_IN}},
        '{ROW_TICK, CFG_FADE_IN,  16'h0000, 1'b0, 1'b1, t_out_word'{17'd0, 1'b1, PH_IN}},
        '{ROW_TICK, CFG_FADE_IN,  16'h0000, 1'b0, 1'b1, t_out_word'{17'd0, 1'b1, PH_IN}},
        '{ROW_TICK, CFG_FADE_IN,  16'h0001, 1'b0, 1'b1, t_out_word'{17'd0, 1'b1, PH_IN}},
        '{ROW_TICK, CFG_FADE_IN,  16'h00FF, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FADE_IN,  16'h5555, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_FADE_IN,  16'h2AAA, 1'b0, 1'b0, '0}
    };

    // Add milliseconds to the accumulator, clamping at its top.
    function automatic logic [STEP_W-1:0] add_clamped(input logic [STEP_W-1:0] acc,
                                                      input logic [MS_W-1:0] ms);
        logic [STEP_W:0] sum;
        sum = {1'b0, acc} + (STEP_W + 1)'(ms);
        return (sum > {1'b0, STEP_MAX}) ? STEP_MAX : sum[STEP_W-1:0];
    endfunction

    // Advance the mirror by one tick and give the level word it produces.
    function automatic t_out_word envelope_tick(input t_in_word w);
        t_out_word         r;
        logic [63:0]       ratio;
        logic [STEP_W-1:0] hold_len;
        r = '0;
        // the stop request counts for this very tick
        if (w.stop_hold)
            hold_dropped = 1'b1;
        hold_len = hold_dropped ? '0 : STEP_W'(hold_time_ms);
        case (env_phase)
            PH_START, PH_START2: begin
                r.fade_written = (ramp_in_ms != '0);
                env_step       = '0;
                env_phase      = (env_phase == PH_START) ? PH_START2 : PH_IN;
            end
            PH_IN: begin
                if (env_step < STEP_W'(ramp_in_ms)) begin
                    ratio          = (64'(env_step) << 16) / 64'(ramp_in_ms);
                    r.fade_level   = ratio[LEVEL_W-1:0];
                    r.fade_written = 1'b1;
                    env_step       = add_clamped(env_step, w.elapsed_ms);
                end else begin
                    r.fade_level   = FULL_LEVEL;
                    r.fade_written = 1'b1;
                    env_step       = '0;
                    env_phase      = PH_HOLD;
                end
            end
            PH_HOLD: begin
                // nothing is written while holding
                if (env_step < hold_len) begin
                    env_step = add_clamped(env_step, w.elapsed_ms);
                end else begin
                    env_step  = '0;
                    env_phase = PH_OUT;
                end
            end
            PH_OUT: begin
                if (ramp_out_ms == '0) begin
                    // no ramp out: snap to full, then finish
                    r.fade_level   = FULL_LEVEL;
                    r.fade_written = 1'b1;
                    env_step       = '0;
                    env_phase      = PH_DONE;
                end else if (env_step < STEP_W'(ramp_out_ms)) begin
                    ratio          = ((64'(ramp_out_ms) - 64'(env_step)) << 16)
                                     / 64'(ramp_out_ms);
                    r.fade_level   = ratio[LEVEL_W-1:0];
                    r.fade_written = 1'b1;
                    env_step       = add_clamped(env_step, w.elapsed_ms);
                end else begin
                    r.fade_written = 1'b1;
                    env_step       = '0;
                    env_phase      = PH_DONE;
                end
            end
            default: begin
            end
        endcase
        r.phase_now = env_phase;
        return r;
    endfunction

    // Mostly short frame times, now and then anything the field holds.
    function automatic logic [MS_W-1:0] pick_elapsed(input int big_odds);
        if ($urandom_range(0, big_odds - 1) == 0)
            return MS_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            return MS_W'($urandom_range(0, 1023));
        return MS_W'($urandom_range(0, 63));
    endfunction

    // A random duration above the accumulator, where the field allows, to keep the current ramp or hold going.
    function automatic logic [MS_W-1:0] above_step();
        if (env_step >= STEP_W'(16'hFFFF))
            return 16'hFFFF;
        return MS_W'($urandom_range(int'(env_step) + 1, 65535));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Write one register; the enable stays up until the next word or pause.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_FADE_IN:  ramp_in_ms   = value;
            CFG_FADE_OUT: ramp_out_ms  = value;
            CFG_HOLD:     hold_time_ms = value;
            default: begin
            end
        endcase
    endtask

    // Hold the sender until every owed level has come back.
    task automatic settle();
        tick_ch.valid <= 1'b0;
        cfg_we        <= 1'b0;
        do @(posedge i_clk); while (due_words.size() != 0);
    endtask

    // Offer one tick word in bursts with random gaps, and log what it owes.
    task automatic send_tick(input logic [MS_W-1:0] ms, input logic stop,
                             input logic typed, input t_out_word typed_word);
        t_in_word  w;
        t_out_word predicted;
        cfg_we <= 1'b0;
        if (burst_left == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        w.elapsed_ms = ms;
        w.stop_hold  = stop;
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= w;
        do @(posedge i_clk); while (!tick_ch.ready);
        predicted = envelope_tick(w);
        due_words.push_back(typed ? typed_word : predicted);
        burst_left--;
    endtask

    // Keep the block in one phase, in whole segments until a budget of ticks is met, moving the
    // relevant duration past the accumulator before each segment.
    task automatic run_stage(input t_phase stage, input logic [CFG_IDX_W-1:0] idx,
                             input int budget, input logic free_stop);
        int n;
        n = 0;
        while (env_phase == stage && n < budget) begin
            settle();
            write_reg(idx, above_step());
            repeat (SEGMENT_TICKS) begin
                send_tick(pick_elapsed(40), free_stop ? 1'($urandom_range(0, 1)) : 1'b0,
                          1'b0, '0);
                n++;
            end
        end
        ticks_sent += n;
    endtask

    // Receiver: cycle through steady, light, heavy and periodic back-pressure.
    always @(posedge i_clk) begin
        stall_clock <= stall_clock + 1;
        case ((stall_clock / 300) % 4)
            0:       level_ch.ready <= 1'b1;
            1:       level_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       level_ch.ready <= 1'($urandom_range(0, 1));
            default: level_ch.ready <= ((stall_clock % 23) < 15);
        endcase
    end

    // Compare each accepted level word with the oldest one owed.
    always @(posedge i_clk) begin : check_levels
        t_out_word want;
        if (i_rst_n && level_ch.valid && level_ch.ready) begin
            if (due_words.size() == 0) begin
                report_mismatch("level word with nothing owed, fade_level",
                                int'(level_ch.data.fade_level), 0);
            end else begin
                want = due_words.pop_front();
                if (level_ch.data.fade_level !== want.fade_level)
                    report_mismatch("fade_level", int'(level_ch.data.fade_level),
                                    int'(want.fade_level));
                if (level_ch.data.fade_written !== want.fade_written)
                    report_mismatch("fade_written", int'(level_ch.data.fade_written),
                                    int'(want.fade_written));
                if (level_ch.data.phase_now !== want.phase_now)
                    report_mismatch("phase_now", int'(level_ch.data.phase_now),
                                    int'(want.phase_now));
            end
        end
    end

    // Drop the run if no word moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) || (level_ch.valid && level_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int done_ticks;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_FADE_IN;
        cfg_data       = '0;
        tick_ch.valid  = 1'b0;
        tick_ch.data   = '0;
        level_ch.ready = 1'b0;
        env_phase      = PH_START;
        env_step       = '0;
        hold_dropped   = 1'b0;
        ramp_in_ms     = '0;
        ramp_out_ms    = '0;
        hold_time_ms   = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the opening table; registers only change with nothing in flight.
        foreach (opening_rows[r]) begin
            if (opening_rows[r].kind == ROW_REG) begin
                settle();
                write_reg(opening_rows[r].idx, opening_rows[r].value);
            end else begin
                send_tick(opening_rows[r].value, opening_rows[r].stop,
                          opening_rows[r].typed, opening_rows[r].result);
            end
        end

        // Fade in at random lengths, then leave with the ramp switched off.
        run_stage(PH_IN, CFG_FADE_IN, 300, 1'b0);
        if (env_phase == PH_IN) begin
            settle();
            write_reg(CFG_FADE_IN, '0);
            send_tick(pick_elapsed(40), 1'b0, 1'b1, t_out_word'{FULL_LEVEL, 1'b1, PH_HOLD});
        end

        // Hold, then leave by a stop request or by a zero hold time.
        run_stage(PH_HOLD, CFG_HOLD, 150, 1'b0);
        if (env_phase == PH_HOLD) begin
            if ($urandom_range(0, 1) == 0) begin
                send_tick(pick_elapsed(40), 1'b1, 1'b1, t_out_word'{17'd0, 1'b0, PH_OUT});
            end else begin
                settle();
                write_reg(CFG_HOLD, '0);
                send_tick(pick_elapsed(40), 1'b0, 1'b1, t_out_word'{17'd0, 1'b0, PH_OUT});
            end
        end

        // Fade out, then finish either by snapping to full or by running out.
        run_stage(PH_OUT, CFG_FADE_OUT, 300, 1'b1);
        if (env_phase == PH_OUT) begin
            settle();
            if ($urandom_range(0, 1) == 0 || env_step == '0) begin
                write_reg(CFG_FADE_OUT, '0);
                send_tick(pick_elapsed(40), 1'($urandom_range(0, 1)), 1'b1,
                          t_out_word'{FULL_LEVEL, 1'b1, PH_DONE});
            end else begin
                write_reg(CFG_FADE_OUT, (env_step > STEP_W'(16'hFFFF)) ? 16'hFFFF
                                                                       : env_step[MS_W-1:0]);
                send_tick(pick_elapsed(40), 1'($urandom_range(0, 1)), 1'b1,
                          t_out_word'{17'd0, 1'b1, PH_DONE});
            end
        end

        // Done: any tick and any register setting must leave the block quiet.
        done_ticks = (RANDOM_TICKS - ticks_sent > 60) ? RANDOM_TICKS - ticks_sent : 60;
        settle();
        write_reg(CFG_FADE_OUT, '0);
        write_reg(CFG_HOLD, '0);
        write_reg(CFG_FADE_IN, MS_W'($urandom));
        repeat (done_ticks / 2)
            send_tick(pick_elapsed(1), 1'($urandom_range(0, 1)), 1'b0, '0);
        settle();
        write_reg(CFG_FADE_OUT, MS_W'($urandom));
        write_reg(CFG_HOLD, 16'hFFFF);
        repeat (done_ticks - done_ticks / 2)
            send_tick(pick_elapsed(1), 1'($urandom_range(0, 1)), 1'b0, '0);

        // Wait for the last level, then give stray words a chance to show.
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
